// ===== rtl/fac_pkg.sv =====
package fac_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;

   localparam int CENTER_W = 32;
   localparam int HALF_W = 31;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_INDEX_W = 4;
   localparam int NUM_REGS = 8;
   localparam int NUM_PLANES = 6;
   localparam int SLOT_W = 32;

   localparam logic [CSR_DATA_W-1:0] MAT_RESET [NUM_REGS] = '{
      64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
   };

   typedef enum logic [1:0] {
      TERM_ADD,
      TERM_SUB,
      TERM_NONE
   } term_type;

   localparam logic [1:0] PLANE_COL_A [NUM_PLANES] = '{2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd3};
   localparam logic [1:0] PLANE_COL_B [NUM_PLANES] = '{2'd3, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2};
   localparam term_type PLANE_TERM_B [NUM_PLANES] = '{
      TERM_ADD, TERM_SUB, TERM_ADD, TERM_SUB, TERM_NONE, TERM_SUB
   };

   typedef enum logic [1:0] {
      VERDICT_OUTSIDE   = 2'd0,
      VERDICT_INTERSECT = 2'd1,
      VERDICT_INSIDE    = 2'd2
   } verdict_type;

   typedef struct packed {
      logic valid;
      logic any_out;
      logic all_in;
   } ctl_type;

   typedef struct packed {
      logic [2:0][CENTER_W-1:0] center;
      logic [2:0][HALF_W-1:0]   half;
   } box_type;

endpackage

// ===== rtl/frustum_aabb_cull.sv =====
// rsp_valid is registered behind the last plane cell. Throughput: one
// request per cycle while busy is low; the six plane cells, three stages
// each, run as one pipeline. busy is high during reset, in a cycle with
// csr_write_en high and in the cycle after, while the plane registers reload.
// Reset: synchronous, active high; loads the identity matrix and drops all
// requests in flight. The receiver cannot stall rsp_valid.
module frustum_aabb_cull #(
   parameter int COORD_WIDTH = fac_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS = fac_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [fac_pkg::CENTER_W-1:0] req_center_x,
   input  logic signed [fac_pkg::CENTER_W-1:0] req_center_y,
   input  logic signed [fac_pkg::CENTER_W-1:0] req_center_z,
   input  logic        [fac_pkg::HALF_W-1:0]   req_half_size_x,
   input  logic        [fac_pkg::HALF_W-1:0]   req_half_size_y,
   input  logic        [fac_pkg::HALF_W-1:0]   req_half_size_z,
   output logic                                rsp_valid,
   output logic        [1:0]                   rsp_verdict,
   input  logic                                csr_write_en,
   input  logic        [fac_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [fac_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW = COORD_WIDTH;
   localparam int NP = fac_pkg::NUM_PLANES;

   logic [fac_pkg::CSR_DATA_W-1:0] mat_ff [fac_pkg::NUM_REGS];
   logic signed [CW:0] plane_in [NP][4];
   logic signed [CW:0] plane_ff [NP][4];
   logic               cfg_hold_ff;

   fac_pkg::ctl_type ctl_chain [NP+1];
   fac_pkg::box_type box_chain [NP+1];

   logic                 rsp_valid_ff;
   fac_pkg::verdict_type rsp_verdict_ff, rsp_verdict_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fac_pkg::NUM_REGS; i++) begin
            mat_ff[i] <= fac_pkg::MAT_RESET[i];
         end
      end else if (csr_write_en && (csr_index < fac_pkg::CSR_INDEX_W'(fac_pkg::NUM_REGS))) begin
         mat_ff[csr_index[2:0]] <= csr_wdata;
      end
   end

   always_comb begin
      logic signed [CW-1:0] ent_a;
      logic signed [CW-1:0] ent_b;
      for (int p = 0; p < NP; p++) begin
         for (int r = 0; r < 4; r++) begin
            ent_a = signed'(mat_ff[{fac_pkg::PLANE_COL_A[p], 1'(r / 2)}]
                                  [fac_pkg::SLOT_W * (r % 2) +: CW]);
            ent_b = signed'(mat_ff[{fac_pkg::PLANE_COL_B[p], 1'(r / 2)}]
                                  [fac_pkg::SLOT_W * (r % 2) +: CW]);
            case (fac_pkg::PLANE_TERM_B[p])
               fac_pkg::TERM_ADD: plane_in[p][r] = (CW + 1)'(ent_a) + (CW + 1)'(ent_b);
               fac_pkg::TERM_SUB: plane_in[p][r] = (CW + 1)'(ent_a) - (CW + 1)'(ent_b);
               default:           plane_in[p][r] = (CW + 1)'(ent_a);
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      plane_ff <= plane_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_hold_ff <= 1'b0;
      end else begin
         cfg_hold_ff <= csr_write_en;
      end
   end

   assign busy = reset | csr_write_en | cfg_hold_ff;

   always_comb begin
      ctl_chain[0].valid = start & ~busy;
      ctl_chain[0].any_out = 1'b0;
      ctl_chain[0].all_in = 1'b1;
      box_chain[0].center[0] = req_center_x;
      box_chain[0].center[1] = req_center_y;
      box_chain[0].center[2] = req_center_z;
      box_chain[0].half[0] = req_half_size_x;
      box_chain[0].half[1] = req_half_size_y;
      box_chain[0].half[2] = req_half_size_z;
   end

   for (genvar p = 0; p < NP; p++) begin : g_cell
      fac_plane_cell #(
         .COORD_WIDTH(COORD_WIDTH),
         .FRAC_BITS(FRAC_BITS)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .plane(plane_ff[p]),
         .in_ctl(ctl_chain[p]),
         .in_box(box_chain[p]),
         .out_ctl(ctl_chain[p+1]),
         .out_box(box_chain[p+1])
      );
   end

   always_comb begin
      if (ctl_chain[NP].any_out) begin
         rsp_verdict_in = fac_pkg::VERDICT_OUTSIDE;
      end else if (ctl_chain[NP].all_in) begin
         rsp_verdict_in = fac_pkg::VERDICT_INSIDE;
      end else begin
         rsp_verdict_in = fac_pkg::VERDICT_INTERSECT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl_chain[NP].valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_verdict_ff <= rsp_verdict_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

endmodule

// ===== rtl/fac_plane_cell.sv =====
module fac_plane_cell #(
   parameter int COORD_WIDTH = fac_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS = fac_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [COORD_WIDTH:0]   plane [4],
   input  fac_pkg::ctl_type              in_ctl,
   input  fac_pkg::box_type              in_box,
   output fac_pkg::ctl_type              out_ctl,
   output fac_pkg::box_type              out_box
);

   localparam int CW = COORD_WIDTH;
   localparam int PW = 2 * CW + 1;
   localparam int EW = 2 * CW;
   localparam int SUM_W = ((2 * CW + 1 > CW + 1 + FRAC_BITS) ? 2 * CW + 1
                                                             : CW + 1 + FRAC_BITS) + 4;

   logic signed [CW-1:0] cen [3];
   logic        [CW:0]   mag [3];
   logic        [CW-2:0] half [3];

   logic signed [PW-1:0]    dp_in [3];
   logic signed [PW-1:0]    dp_ff [3];
   logic        [EW-1:0]    ep_in [3];
   logic        [EW-1:0]    ep_ff [3];
   logic signed [SUM_W-1:0] dterm_in, dterm_ff;
   fac_pkg::ctl_type        ctl_a_ff;
   fac_pkg::box_type        box_a_ff;

   logic signed [SUM_W-1:0] dist_in, dist_ff;
   logic        [SUM_W-1:0] ext_in, ext_ff;
   fac_pkg::ctl_type        ctl_b_ff;
   fac_pkg::box_type        box_b_ff;

   logic signed [SUM_W-1:0] hi_sum, lo_sum;
   fac_pkg::ctl_type        ctl_c_in, ctl_c_ff;
   fac_pkg::box_type        box_c_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         cen[r] = signed'(in_box.center[r][CW-1:0]);
         half[r] = in_box.half[r][CW-2:0];
         mag[r] = plane[r][CW] ? unsigned'(-plane[r]) : unsigned'(plane[r]);
         dp_in[r] = plane[r] * cen[r];
         ep_in[r] = mag[r] * half[r];
      end
      dterm_in = SUM_W'(plane[3]) <<< FRAC_BITS;
   end

   always_comb begin
      dist_in = SUM_W'(dp_ff[0]) + SUM_W'(dp_ff[1]) + SUM_W'(dp_ff[2]) + dterm_ff;
      ext_in = SUM_W'(ep_ff[0]) + SUM_W'(ep_ff[1]) + SUM_W'(ep_ff[2]);
   end

   always_comb begin
      hi_sum = dist_ff + signed'(ext_ff);
      lo_sum = dist_ff - signed'(ext_ff);
      ctl_c_in.valid = ctl_b_ff.valid;
      ctl_c_in.any_out = ctl_b_ff.any_out | hi_sum[SUM_W-1];
      ctl_c_in.all_in = ctl_b_ff.all_in & ~lo_sum[SUM_W-1] & (lo_sum != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
         ctl_c_ff <= '0;
      end else begin
         ctl_a_ff <= in_ctl;
         ctl_b_ff <= ctl_a_ff;
         ctl_c_ff <= ctl_c_in;
      end
   end

   always_ff @(posedge clock) begin
      dp_ff <= dp_in;
      ep_ff <= ep_in;
      dterm_ff <= dterm_in;
      box_a_ff <= in_box;
      dist_ff <= dist_in;
      ext_ff <= ext_in;
      box_b_ff <= box_a_ff;
      box_c_ff <= box_b_ff;
   end

   assign out_ctl = ctl_c_ff;
   assign out_box = box_c_ff;

endmodule
